// ===== rtl/core/sbgc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbgc_pkg
// shared constants, register map and sine table function
// ----------------------------------------------------------------------------
package sbgc_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int BEAM_INDEX_BITS_DEF = 12;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_ANGLE_START = 3'd0,
        REG_ANGLE_STEP  = 3'd1,
        REG_RANGE_MIN   = 3'd2,
        REG_RANGE_MAX   = 3'd3,
        REG_PIXEL_SCALE = 3'd4,
        REG_IMAGE_SIZE  = 3'd5,
        REG_GRID_SCALE  = 3'd6,
        REG_GRID_SIZE   = 3'd7
    } t_reg_idx;

    localparam logic [15:0] RST_RANGE_MAX   = 16'd65535;
    localparam logic [15:0] RST_PIXEL_SCALE = 16'd5243;
    localparam logic [11:0] RST_IMAGE_SIZE  = 12'd800;
    localparam logic [15:0] RST_GRID_SCALE  = 16'd24576;
    localparam logic [9:0]  RST_GRID_SIZE   = 10'd300;

    typedef struct packed {
        logic [15:0] range_lo;
        logic [15:0] range_hi;
        logic [15:0] pixel_scale;
        logic [11:0] image_size;
        logic [15:0] grid_scale;
        logic [9:0]  grid_size;
    } t_cfg;

    // signed Q16 sine for a table index of tb bits
    function automatic logic signed [17:0] sine_entry(input logic [13:0] idx, input int tb);
        logic [1:0]  quad;
        logic [16:0] z;
        logic [33:0] zz;
        logic [33:0] z2;
        logic [50:0] r;
        logic [50:0] s;
        quad = 2'((idx >> (tb - 2)) & 14'd3);
        z    = 17'((idx & ((14'd1 << (tb - 2)) - 14'd1)) << (18 - tb));
        if (quad[0]) z = 17'd65536 - z;
        zz = 34'(z) * 34'(z);
        z2 = zz >> 16;
        r  = 51'd11;
        r  = 51'd307    - ((51'(z2) * r) >> 16);
        r  = 51'd5223   - ((51'(z2) * r) >> 16);
        r  = 51'd42334  - ((51'(z2) * r) >> 16);
        r  = 51'd102944 - ((51'(z2) * r) >> 16);
        s  = (51'(z) * r) >> 16;
        if (s > 51'd65536) s = 51'd65536;
        return quad[1] ? -$signed({1'b0, s[16:0]}) : $signed({1'b0, s[16:0]});
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sbgc_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbgc_pipe
// seven stage beam to cell datapath with per stage valid and global enable
// ----------------------------------------------------------------------------
module sbgc_pipe
    import sbgc_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int BEAM_INDEX_BITS = BEAM_INDEX_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [BEAM_INDEX_BITS-1:0] i_beam_index,
    input  wire logic [15:0]                i_range_mm,
    input  wire logic                       i_scan_start,
    input  wire logic [15:0]                i_angle_start,
    input  wire logic [15:0]                i_angle_step,
    input  wire t_cfg                       i_cfg,
    output logic                            o_valid,
    output logic [19:0]                     o_cell_index,
    output logic                            o_hit,
    output logic                            o_scan_start
);

    localparam int NS = 7;
    localparam int TN = 1 << SINE_TABLE_BITS;
    localparam int QT = TN / 4;
    localparam int QN = 1 << (SINE_TABLE_BITS - 2);

    // quarter wave magnitudes, entry QN is the peak
    logic [16:0] w_qtab [QN+1];

    for (genvar k = 0; k <= QN; k++) begin : g_qtab
        localparam logic signed [17:0] QV = sine_entry(14'(k), SINE_TABLE_BITS);
        assign w_qtab[k] = QV[16:0];
    end

    logic [NS-1:0] r_v;
    logic [NS-1:0] r_ss;
    logic [NS-1:0] r_ok;

    // stage 1: angle
    logic [15:0] r1_ang;
    logic [15:0] r1_r;
    // stage 2: table lookup
    logic signed [17:0] r2_cos, r2_sin;
    logic [15:0]        r2_r;
    // stage 3: point in mm, Q16
    logic signed [34:0] r3_x, r3_y;
    // stage 4: pixel, Q32
    logic signed [52:0] r4_px, r4_py;
    logic               r4_lim;
    // stage 5: grid, Q48, and edge
    logic [68:0] r5_gx, r5_gy;
    logic [16:0] r5_edge;
    // stage 6: ceilings
    logic [21:0] r6_cx, r6_cy;
    // stage 7
    logic [19:0] r7_cell;

    logic [SINE_TABLE_BITS-1:0] w_si, w_ci;
    logic [SINE_TABLE_BITS-2:0] w_sa, w_ca;
    logic signed [52:0] w_org, w_lim, w_px, w_py;
    logic signed [23:0] w_t;
    logic signed [23:0] w_gg;

    assign w_si  = r1_ang[15 -: SINE_TABLE_BITS];
    assign w_ci  = w_si + SINE_TABLE_BITS'(QT);
    // odd quadrants read the quarter wave backwards
    assign w_sa  = w_si[SINE_TABLE_BITS-2]
                 ? {1'b1, {(SINE_TABLE_BITS-2){1'b0}}} - {1'b0, w_si[SINE_TABLE_BITS-3:0]}
                 : {1'b0, w_si[SINE_TABLE_BITS-3:0]};
    assign w_ca  = w_ci[SINE_TABLE_BITS-2]
                 ? {1'b1, {(SINE_TABLE_BITS-2){1'b0}}} - {1'b0, w_ci[SINE_TABLE_BITS-3:0]}
                 : {1'b0, w_ci[SINE_TABLE_BITS-3:0]};
    assign w_org = $signed({9'd0, 12'((13'(i_cfg.image_size) + 13'd1) >> 1), 32'd0})
                 - 53'sd2147483648;
    assign w_lim = $signed({9'd0, i_cfg.image_size, 32'd0});
    assign w_px  = r3_x * $signed({1'b0, i_cfg.pixel_scale}) + w_org;
    assign w_py  = r3_y * $signed({1'b0, i_cfg.pixel_scale}) + w_org;
    assign w_gg  = $signed({14'd0, i_cfg.grid_size});
    assign w_t   = (w_gg - $signed({2'b0, r6_cx})) * w_gg + $signed({2'b0, r6_cy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ss   <= {r_ss[NS-2:0], i_scan_start};
            r1_ang <= i_angle_start + 16'(32'(i_angle_step) * 32'(i_beam_index));
            r1_r   <= i_range_mm;
            r_ok[0] <= (i_range_mm > i_cfg.range_lo) && (i_range_mm < i_cfg.range_hi);

            r2_cos <= w_ci[SINE_TABLE_BITS-1] ? -$signed({1'b0, w_qtab[w_ca]})
                                              : $signed({1'b0, w_qtab[w_ca]});
            r2_sin <= w_si[SINE_TABLE_BITS-1] ? -$signed({1'b0, w_qtab[w_sa]})
                                              : $signed({1'b0, w_qtab[w_sa]});
            r2_r   <= r1_r;
            r_ok[1] <= r_ok[0];

            r3_x <= -($signed({1'b0, r2_r}) * r2_cos);
            r3_y <= -($signed({1'b0, r2_r}) * r2_sin);
            r_ok[2] <= r_ok[1];

            r4_px <= w_px;
            r4_py <= w_py;
            r_ok[3] <= r_ok[2];

            r4_lim <= (w_px > 0) && (w_px < w_lim) && (w_py > 0) && (w_py < w_lim);
            r5_gx <= 69'(r4_px[51:0]) * 69'(i_cfg.grid_scale);
            r5_gy <= 69'(r4_py[51:0]) * 69'(i_cfg.grid_scale);
            r5_edge <= 17'((28'(i_cfg.image_size) * 28'(i_cfg.grid_scale) + 28'd65535) >> 16);
            r_ok[4] <= r_ok[3] && r4_lim;

            r6_cx <= 22'((r5_gx + {21'd0, {48{1'b1}}}) >> 48);
            r6_cy <= 22'((r5_gy + {21'd0, {48{1'b1}}}) >> 48);
            r_ok[5] <= r_ok[4] && ((21'(r5_gy + {21'd0, {48{1'b1}}} >> 48) < 21'(r5_edge))
                    || (21'(r5_gx + {21'd0, {48{1'b1}}} >> 48) < 21'(r5_edge)));

            r7_cell <= w_t[19:0];
            r_ok[6] <= r_ok[5] && (w_t >= 0)
                    && (w_t < $signed({4'd0, 20'(20'(i_cfg.grid_size) * 20'(i_cfg.grid_size))}));
        end
    end

    assign o_valid      = r_v[NS-1];
    assign o_hit        = r_ok[NS-1];
    assign o_cell_index = r_ok[NS-1] ? r7_cell : 20'd0;
    assign o_scan_start = r_ss[NS-1];

endmodule
`default_nettype wire

// ===== rtl/core/scan_beam_to_grid_cell_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scan_beam_to_grid_cell_top
// converts one lidar beam per request into an occupancy grid cell index
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata {range_mm, beam_index}, tuser scan_start
// m_axis   out  tdata cell_index, tuser {scan_start_out, hit}
// apb      in   eight config registers at 4*i
// one request per cycle while the output is not stalled, passing through the datapath
// stages plus one output register; the stage chain moves only when the output
// register is free or being drained, so a stall holds every stage
// reset clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
module scan_beam_to_grid_cell_top
    import sbgc_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
    parameter int BEAM_INDEX_BITS = BEAM_INDEX_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [((BEAM_INDEX_BITS + 23) / 8) * 8 - 1:0]
                                    s_axis_tdata,   // beam_index, range_mm
    input  wire logic               s_axis_tuser,   // scan_start
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [23:0]             m_axis_tdata,   // cell_index
    output logic [1:0]              m_axis_tuser,   // hit, scan_start_out
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [15:0] r_angle_start, r_angle_step;
    t_cfg        r_cfg;
    logic        w_en, w_pv, w_hit, w_ss;
    logic [19:0] w_cell;
    logic        r_ov;
    logic [19:0] r_cell;
    logic        r_hit, r_ss;
    t_reg_idx    w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start     <= '0;
            r_angle_step      <= '0;
            r_cfg.range_lo    <= '0;
            r_cfg.range_hi    <= RST_RANGE_MAX;
            r_cfg.pixel_scale <= RST_PIXEL_SCALE;
            r_cfg.image_size  <= RST_IMAGE_SIZE;
            r_cfg.grid_scale  <= RST_GRID_SCALE;
            r_cfg.grid_size   <= RST_GRID_SIZE;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            case (w_idx)
                REG_ANGLE_START: r_angle_start     <= pwdata[15:0];
                REG_ANGLE_STEP:  r_angle_step      <= pwdata[15:0];
                REG_RANGE_MIN:   r_cfg.range_lo    <= pwdata[15:0];
                REG_RANGE_MAX:   r_cfg.range_hi    <= pwdata[15:0];
                REG_PIXEL_SCALE: r_cfg.pixel_scale <= pwdata[15:0];
                REG_IMAGE_SIZE:  r_cfg.image_size  <= pwdata[11:0];
                REG_GRID_SCALE:  r_cfg.grid_scale  <= pwdata[15:0];
                REG_GRID_SIZE:   r_cfg.grid_size   <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ANGLE_START: prdata = {16'd0, r_angle_start};
            REG_ANGLE_STEP:  prdata = {16'd0, r_angle_step};
            REG_RANGE_MIN:   prdata = {16'd0, r_cfg.range_lo};
            REG_RANGE_MAX:   prdata = {16'd0, r_cfg.range_hi};
            REG_PIXEL_SCALE: prdata = {16'd0, r_cfg.pixel_scale};
            REG_IMAGE_SIZE:  prdata = {20'd0, r_cfg.image_size};
            REG_GRID_SCALE:  prdata = {16'd0, r_cfg.grid_scale};
            REG_GRID_SIZE:   prdata = {22'd0, r_cfg.grid_size};
            default:         prdata = '0;
        endcase
    end

    assign w_en          = !r_ov || m_axis_tready;
    assign s_axis_tready = w_en;

    sbgc_pipe #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .BEAM_INDEX_BITS (BEAM_INDEX_BITS)
    ) u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (s_axis_tvalid),
        .i_beam_index  (s_axis_tdata[BEAM_INDEX_BITS-1:0]),
        .i_range_mm    (s_axis_tdata[BEAM_INDEX_BITS +: 16]),
        .i_scan_start  (s_axis_tuser),
        .i_angle_start (r_angle_start),
        .i_angle_step  (r_angle_step),
        .i_cfg         (r_cfg),
        .o_valid       (w_pv),
        .o_cell_index  (w_cell),
        .o_hit         (w_hit),
        .o_scan_start  (w_ss)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cell <= w_cell;
            r_hit  <= w_hit;
            r_ss   <= w_ss;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'd0, r_cell};
    assign m_axis_tuser  = {r_ss, r_hit};

endmodule
`default_nettype wire
